>>> src/cds_pkg.sv
// Shared types, constants and saturation helpers for the critically damped smoother.
// Used by cds_lane and the top level; no dependencies.
package cds_pkg;

  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] REG_SMOOTH_TIME = 1'b0;
  localparam logic [RegIdxW-1:0] REG_MAX_SPEED   = 1'b1;

  localparam int unsigned MaxAxes = 3;
  localparam logic [30:0] ST_FLOOR = 31'd7;
  localparam logic [14:0] C048     = 15'd31457;
  localparam logic [13:0] C0235    = 14'd15401;

  localparam logic signed [47:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [49:0] WMAX50   = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S32_MAX  = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] S32_MIN  = -48'sh0000_8000_0000;

  // shared scalars handed to every lane
  typedef struct packed {
    logic        start;
    logic [30:0] omega;
    logic [15:0] dt;
    logic [16:0] k;
    logic [45:0] lim;
  } lane_ctl_t;

  function automatic logic signed [47:0] satw(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > WMAX50) r = WIDE_MAX;
    else if (v < -WMAX50) r = -WIDE_MAX;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/cds_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on no other file.
module cds_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [33:0] quo
);
  logic [39:0] rem;
  logic [33:0] dvd;
  logic [39:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, dvd[33]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        rem  <= '0;
        dvd  <= num;
        dsr  <= den;
      end else if (busy) begin
        rem <= fits ? 40'(rem_sh - {1'b0, dsr}) : rem_sh[39:0];
        dvd <= {dvd[32:0], 1'b0};
        quo <= {quo[32:0], fits};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end
endmodule

>>> src/cds_lane.sv
// One axis of the smoother: error clamp, five Q16.16 products, overshoot test.
// Depends on cds_pkg; holds the axis velocity.
module cds_lane (
  input  logic               clk,
  input  logic               rst,
  input  cds_pkg::lane_ctl_t ctl,
  input  logic signed [31:0] cur,
  input  logic signed [31:0] goal,
  output logic               done,
  output logic signed [31:0] pos
);
  import cds_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_M1   = 3'd1;
  localparam logic [2:0] L_M2   = 3'd2;
  localparam logic [2:0] L_M3   = 3'd3;
  localparam logic [2:0] L_M4   = 3'd4;
  localparam logic [2:0] L_M5   = 3'd5;
  localparam logic [2:0] L_FIN  = 3'd6;

  logic [2:0]         op;
  logic [1:0]         phase;
  logic signed [31:0] vel;
  logic signed [32:0] err;
  logic signed [33:0] tgt;
  logic signed [47:0] drift, nv, np;
  logic [77:0]        acc;

  logic signed [32:0] diff;
  logic signed [46:0] lim_s;
  logic signed [32:0] err_c;
  logic signed [47:0] a_sel, a_abs, p, m;
  logic [30:0]        b_sel;
  logic [46:0]        ma;
  logic [54:0]        prod_lo;
  logic [53:0]        prod_hi;
  logic [61:0]        pq;
  logic               overshoot;

  assign diff  = 33'(cur) - 33'(goal);
  assign lim_s = $signed({1'b0, ctl.lim});
  always_comb begin
    if (47'(diff) > lim_s) err_c = 33'(lim_s);
    else if (47'(diff) < -lim_s) err_c = 33'(-lim_s);
    else err_c = diff;
  end

  always_comb begin
    case (op)
      L_M1:    begin a_sel = 48'(err);   b_sel = ctl.omega;        end
      L_M2:    begin a_sel = drift;      b_sel = 31'(ctl.dt);      end
      L_M3:    begin a_sel = drift;      b_sel = ctl.omega;        end
      L_M4:    begin a_sel = nv;         b_sel = 31'(ctl.k);       end
      L_M5:    begin a_sel = satw(50'(err) + 50'(drift)); b_sel = 31'(ctl.k); end
      default: begin a_sel = '0;         b_sel = '0;               end
    endcase
  end

  assign a_abs   = a_sel[47] ? -a_sel : a_sel;
  assign ma      = a_abs[46:0];
  assign prod_lo = ma[23:0] * b_sel;
  assign prod_hi = ma[46:24] * b_sel;
  assign pq      = acc[77:16];
  assign p       = (pq > 62'(WIDE_MAX)) ? WIDE_MAX : $signed(pq[47:0]);
  assign m       = a_sel[47] ? -p : p;

  assign overshoot = ((33'(goal) - 33'(cur)) > 33'sd0) == (np > 48'(goal));

  always_ff @(posedge clk) begin
    if (rst) begin
      op    <= L_IDLE;
      phase <= '0;
      vel   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (op == L_IDLE) begin
        if (ctl.start) begin
          err   <= err_c;
          tgt   <= 34'(cur) - 34'(err_c);
          op    <= L_M1;
          phase <= 2'd0;
        end
      end else if (op == L_FIN) begin
        if (overshoot) begin
          pos <= goal;
          vel <= '0;
        end else begin
          pos <= sat32(np);
          vel <= sat32(nv);
        end
        done <= 1'b1;
        op   <= L_IDLE;
      end else begin
        case (phase)
          2'd0: begin
            acc   <= 78'(prod_lo);
            phase <= 2'd1;
          end
          2'd1: begin
            acc   <= acc + {prod_hi, 24'd0};
            phase <= 2'd2;
          end
          default: begin
            phase <= 2'd0;
            op    <= op + 3'd1;
            case (op)
              L_M1:    drift <= satw(50'(vel) + 50'(m));
              L_M2:    drift <= m;
              L_M3:    nv    <= satw(50'(vel) - 50'(m));
              L_M4:    nv    <= 48'(sat32(m));
              default: np    <= satw(50'(tgt) + 50'(m));
            endcase
          end
        endcase
      end
    end
  end
endmodule

>>> src/critically_damped_smoother.sv
// Three-axis critically damped spring smoother, Q16.16, parallel axis lanes.
// Steps from input transfer to result valid: omega division, x and decay-factor terms,
// decay-factor division, lane start and five products per lane; the decay-factor division
// is skipped when x is 256.0 or more, as the decay factor is then zero.
// Flow: one item at a time; a new item is taken only after the previous result is pushed,
// and input is taken again while a result still waits in the output register.
// Reset (rst, synchronous): velocities cleared, registers to 1.0, no result pending.
module critically_damped_smoother #(
  parameter int AXES = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cds_pkg::RegIdxW-1:0]  cfg_addr,
  input  logic [30:0]                  cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // current_x, current_y, current_z, goal_x, goal_y, goal_z, step_time (lowest first)
  input  logic [207:0]                 s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // next_x, next_y, next_z (lowest first)
  output logic [95:0]                  m_axis_tdata
);
  import cds_pkg::*;

  localparam int LANES = (AXES < MaxAxes) ? AXES : MaxAxes;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OMEGA = 4'd1;
  localparam logic [3:0] S_X     = 4'd2;
  localparam logic [3:0] S_X2    = 4'd3;
  localparam logic [3:0] S_X3    = 4'd4;
  localparam logic [3:0] S_TERMS = 4'd5;
  localparam logic [3:0] S_DSUM  = 4'd6;
  localparam logic [3:0] S_KDIV  = 4'd7;
  localparam logic [3:0] S_GO    = 4'd8;
  localparam logic [3:0] S_LANE  = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;

  logic [3:0]   state;
  logic [30:0]  smooth_time, max_speed;
  logic [207:0] item;

  // scalar setup values (st is combinational, the rest registered)
  logic [30:0] st, omega, x;
  logic [45:0] lim;
  logic [31:0] x2;
  logic [39:0] x3;
  logic [30:0] t1;
  logic [37:0] t2;
  logic [16:0] k;

  logic        div_start, div_done;
  logic [33:0] div_num, div_quo;
  logic [39:0] div_den;

  logic [46:0] x_prod;
  logic [61:0] lim_prod;
  logic [47:0] x2_prod;
  logic [55:0] x3_prod;
  logic [46:0] t1_prod;
  logic [53:0] t2_prod;

  lane_ctl_t         ctl;
  logic [LANES-1:0]  lane_done;
  logic signed [31:0] lane_pos [MaxAxes];

  assign st       = (smooth_time < ST_FLOOR) ? ST_FLOOR : smooth_time;
  assign x_prod   = omega * item[207:192];
  assign lim_prod = max_speed * st;
  assign x2_prod  = x[23:0] * x[23:0];
  assign x3_prod  = x2 * x[23:0];
  assign t1_prod  = C048 * x2;
  assign t2_prod  = C0235 * x3;

  assign s_axis_tready = (state == S_IDLE);

  // one shared divider: first 2^33 / st, then 2^32 / den
  always_comb begin
    div_start = 1'b0;
    div_num   = 34'h2_0000_0000;
    div_den   = 40'(st);
    if (state == S_IDLE && s_axis_tvalid) begin
      div_start = 1'b1;
    end else if (state == S_DSUM) begin
      div_start = 1'b1;
      div_num   = 34'h1_0000_0000;
      div_den   = 40'd65536 + 40'(x[23:0]) + 40'(t1) + 40'(t2);
    end
  end

  cds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_time <= 31'd65536;
      max_speed   <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SMOOTH_TIME: smooth_time <= cfg_data;
        REG_MAX_SPEED:   max_speed   <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ctl.start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      ctl.start <= 1'b0;
      // shared scalars take the setup registers' values in the following cycle
      ctl.omega <= omega;
      ctl.dt    <= item[207:192];
      ctl.k     <= k;
      ctl.lim   <= lim;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            item  <= s_axis_tdata;
            state <= S_OMEGA;
          end
        end
        S_OMEGA: begin
          if (div_done) begin
            omega <= div_quo[30:0];
            state <= S_X;
          end
        end
        S_X: begin
          x     <= x_prod[46:16];
          lim   <= lim_prod[61:16];
          state <= S_X2;
        end
        S_X2: begin
          // x of 256.0 or more: decay factor is zero
          if (x[30:24] != 7'd0) begin
            k     <= '0;
            state <= S_GO;
          end else begin
            x2    <= x2_prod[47:16];
            state <= S_X3;
          end
        end
        S_X3: begin
          x3    <= x3_prod[55:16];
          state <= S_TERMS;
        end
        S_TERMS: begin
          t1    <= t1_prod[46:16];
          t2    <= t2_prod[53:16];
          state <= S_DSUM;
        end
        S_DSUM: state <= S_KDIV;
        S_KDIV: begin
          if (div_done) begin
            k     <= div_quo[16:0];
            state <= S_GO;
          end
        end
        S_GO: begin
          ctl.start <= 1'b1;
          state     <= S_LANE;
        end
        S_LANE: begin
          if (lane_done[0]) state <= S_PUSH;
        end
        S_PUSH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {lane_pos[2], lane_pos[1], lane_pos[0]};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // lanes; axes not built report zero
  for (genvar g = 0; g < MaxAxes; g++) begin : g_lane
    if (g < LANES) begin : g_on
      cds_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .cur  (item[32*g +: 32]),
        .goal (item[96 + 32*g +: 32]),
        .done (lane_done[g]),
        .pos  (lane_pos[g])
      );
    end else begin : g_off
      assign lane_pos[g] = '0;
    end
  end
endmodule

>>> src/cds_checker.sv
// Port-level checks for the smoother, bound to the top level.
// Depends only on the top level's ports.
module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result pending after reset");
endmodule

bind critically_damped_smoother cds_checker u_cds_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
